@@ rtl/core/sse_pkg.sv @@
// ----------------------------------------------------------------------------
// S/PDIF subframe encoder package
// Shared types, constants and the cell spreading function.
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int unsigned BLOCK_FRAMES = 192;
   localparam int unsigned FRAME_W      = 8;
   localparam int unsigned ADDR_W       = 4;
   localparam int unsigned DATA_W       = 32;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_DEPTH      = 2'd0,
      REG_RATE       = 2'd1,
      REG_COMPRESSED = 2'd2
   } sse_reg_type;

   // Depth selection codes.
   localparam logic [1:0] DEPTH_16 = 2'd0;
   localparam logic [1:0] DEPTH_24 = 2'd1;
   localparam logic [1:0] DEPTH_32 = 2'd2;

   // Rate selection codes and the channel-status rate codes they map to.
   localparam logic [2:0] RATE_SEL_44K1 = 3'd0;
   localparam logic [2:0] RATE_SEL_48K  = 3'd1;
   localparam logic [2:0] RATE_SEL_88K2 = 3'd2;
   localparam logic [2:0] RATE_SEL_96K  = 3'd3;
   localparam logic [7:0] RATE_CODE_44K1 = 8'h00;
   localparam logic [7:0] RATE_CODE_48K  = 8'h02;
   localparam logic [7:0] RATE_CODE_88K2 = 8'h08;
   localparam logic [7:0] RATE_CODE_96K  = 8'h0a;
   localparam logic [7:0] RATE_CODE_NONE = 8'h01;

   // Channel-status bytes.
   localparam logic [7:0] CS_BYTE0_PCM    = 8'h04;
   localparam logic [7:0] CS_BYTE0_NONPCM = 8'h06;
   localparam logic [7:0] CS_BYTE4_16BIT  = 8'h02;
   localparam logic [7:0] CS_BYTE4_24BIT  = 8'h0b;
   localparam logic [4:0] CS_IDX_BYTE0    = 5'd0;
   localparam logic [4:0] CS_IDX_RATE     = 5'd3;
   localparam logic [4:0] CS_IDX_DEPTH    = 5'd4;

   // Preamble cell patterns.
   localparam logic [7:0] PRE_Z = 8'h39;
   localparam logic [7:0] PRE_X = 8'hc9;
   localparam logic [7:0] PRE_Y = 8'h69;

   typedef struct packed {
      logic [1:0] depth_select;
      logic [2:0] rate_select;
      logic       compressed_mode;
   } sse_cfg_type;

   // Biphase-mark cells for 16 slots: the even cell is always 1, the odd
   // cell carries the slot bit.
   function automatic logic [31:0] cells_of_slots(input logic [15:0] bits);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         r[2*i]     = 1'b1;
         r[2*i + 1] = bits[i];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/sse_channels.sv @@
// ----------------------------------------------------------------------------
// S/PDIF subframe encoder channels
// Valid/ready interfaces for the sample input and the subframe output.
// ----------------------------------------------------------------------------
interface sse_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   logic               sample_absent;

   modport source (output valid, output sample, output sample_absent, input ready);
   modport sink   (input valid, input sample, input sample_absent, output ready);
endinterface

interface sse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] cells_first;
   logic [31:0] cells_second;

   modport source (output valid, output cells_first, output cells_second, input ready);
   modport sink   (input valid, input cells_first, input cells_second, output ready);
endinterface

@@ rtl/core/sse_csr.sv @@
// ----------------------------------------------------------------------------
// S/PDIF subframe encoder register file
// APB-style configuration registers: sample depth, rate and compressed mode.
// ----------------------------------------------------------------------------
module sse_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sse_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sse_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sse_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output sse_pkg::sse_cfg_type        cfg
);

   logic [1:0] depth_ff, depth_in;
   logic [2:0] rate_ff, rate_in;
   logic       comp_ff, comp_in;
   logic       write_en;
   sse_pkg::sse_reg_type reg_idx;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = sse_pkg::sse_reg_type'(csr_paddr[3:2]);

   always_comb begin
      depth_in   = depth_ff;
      rate_in    = rate_ff;
      comp_in    = comp_ff;
      csr_prdata = '0;
      case (reg_idx)
         sse_pkg::REG_DEPTH: begin
            csr_prdata = {30'd0, depth_ff};
            if (write_en) depth_in = csr_pwdata[1:0];
         end
         sse_pkg::REG_RATE: begin
            csr_prdata = {29'd0, rate_ff};
            if (write_en) rate_in = csr_pwdata[2:0];
         end
         sse_pkg::REG_COMPRESSED: begin
            csr_prdata = {31'd0, comp_ff};
            if (write_en) comp_in = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= sse_pkg::DEPTH_24;
         rate_ff  <= sse_pkg::RATE_SEL_48K;
         comp_ff  <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         rate_ff  <= rate_in;
         comp_ff  <= comp_in;
      end
   end

   assign cfg.depth_select    = depth_ff;
   assign cfg.rate_select     = rate_ff;
   assign cfg.compressed_mode = comp_ff;

endmodule

@@ rtl/core/spdif_subframe_encoder_top.sv @@
// ----------------------------------------------------------------------------
// S/PDIF subframe encoder
// Turns one PCM sample per item into one biphase-mark subframe of 64 cells.
// ----------------------------------------------------------------------------
// An accepted item is held in the sample register, then in the result register,
// which drives the output.
// Throughput: one item per cycle unless the output stalls under ready.
// Reset (synchronous): empties both stages, restarts at the left subframe of
// frame 0 and loads the register defaults (24 bits, 48 kHz, PCM).
module spdif_subframe_encoder_top (
   input  logic                        clock,
   input  logic                        reset,
   sse_req_if.sink                     req_chan,
   sse_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sse_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sse_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sse_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam logic [sse_pkg::FRAME_W-1:0] LAST_FRAME =
      sse_pkg::FRAME_W'(sse_pkg::BLOCK_FRAMES - 1);

   sse_pkg::sse_cfg_type cfg;

   sse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Channel and frame position of the next item.
   logic                       right_ff, right_in;
   logic [sse_pkg::FRAME_W-1:0] frame_ff, frame_in;

   // Stage 1: captured sample and its position.
   logic                        s1_valid_ff, s1_valid_in;
   logic [31:0]                 s1_sample_ff;
   logic                        s1_right_ff;
   logic [sse_pkg::FRAME_W-1:0] s1_frame_ff;

   // Stage 2: result register.
   logic        s2_valid_ff, s2_valid_in;
   logic [31:0] s2_first_ff, s2_first_in;
   logic [31:0] s2_second_ff, s2_second_in;

   logic s2_ready, s1_ready, req_accept, s1_move;

   assign s2_ready       = ~s2_valid_ff | rsp_chan.ready;
   assign s1_ready       = ~s1_valid_ff | s2_ready;
   assign req_chan.ready = s1_ready;
   assign req_accept     = req_chan.valid & s1_ready;
   assign s1_move        = s1_valid_ff & s2_ready;

   always_comb begin
      right_in = right_ff;
      frame_in = frame_ff;
      if (req_accept) begin
         right_in = ~right_ff;
         if (right_ff) begin
            frame_in = (frame_ff == LAST_FRAME) ? '0 : frame_ff + 1'b1;
         end
      end
      s1_valid_in = req_accept | (s1_valid_ff & ~s2_ready);
      s2_valid_in = s1_move | (s2_valid_ff & ~rsp_chan.ready);
   end

   // Subframe assembly from the captured sample.
   logic [31:0] aligned;
   logic [7:0]  cs_byte;
   logic        cs_bit;
   logic [31:0] payload;
   logic [7:0]  preamble;
   logic [31:0] low_cells;

   always_comb begin
      case (cfg.depth_select)
         sse_pkg::DEPTH_16: aligned = {s1_sample_ff[23:0], 8'd0};
         sse_pkg::DEPTH_32: aligned = {8'd0, s1_sample_ff[31:8]};
         default:           aligned = s1_sample_ff;
      endcase

      case (s1_frame_ff[7:3])
         sse_pkg::CS_IDX_BYTE0: begin
            cs_byte = cfg.compressed_mode ? sse_pkg::CS_BYTE0_NONPCM
                                          : sse_pkg::CS_BYTE0_PCM;
         end
         sse_pkg::CS_IDX_RATE: begin
            case (cfg.rate_select)
               sse_pkg::RATE_SEL_44K1: cs_byte = sse_pkg::RATE_CODE_44K1;
               sse_pkg::RATE_SEL_48K:  cs_byte = sse_pkg::RATE_CODE_48K;
               sse_pkg::RATE_SEL_88K2: cs_byte = sse_pkg::RATE_CODE_88K2;
               sse_pkg::RATE_SEL_96K:  cs_byte = sse_pkg::RATE_CODE_96K;
               default:                cs_byte = sse_pkg::RATE_CODE_NONE;
            endcase
         end
         sse_pkg::CS_IDX_DEPTH: begin
            cs_byte = (cfg.depth_select == sse_pkg::DEPTH_16) ? sse_pkg::CS_BYTE4_16BIT
                                                              : sse_pkg::CS_BYTE4_24BIT;
         end
         default: cs_byte = 8'h00;
      endcase
      cs_bit = cs_byte[s1_frame_ff[2:0]];

      // Slots 4..27 audio, 28 V, 29 U, 30 C; slot 31 gets even parity.
      payload      = {1'b0, cs_bit, 1'b0, cfg.compressed_mode, aligned[23:0], 4'd0};
      payload[31]  = ^payload[30:0];

      if (s1_right_ff)              preamble = sse_pkg::PRE_Y;
      else if (s1_frame_ff == '0)   preamble = sse_pkg::PRE_Z;
      else                          preamble = sse_pkg::PRE_X;

      low_cells    = sse_pkg::cells_of_slots({4'd0, payload[15:4]});
      s2_first_in  = {low_cells[23:0], preamble};
      s2_second_in = sse_pkg::cells_of_slots(payload[31:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff    <= 1'b0;
         frame_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         right_ff    <= right_in;
         frame_ff    <= frame_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_chan.sample_absent ? 32'd0 : 32'(req_chan.sample);
         s1_right_ff  <= right_ff;
         s1_frame_ff  <= frame_ff;
      end
      if (s1_move) begin
         s2_first_ff  <= s2_first_in;
         s2_second_ff <= s2_second_in;
      end
   end

   assign rsp_chan.valid        = s2_valid_ff;
   assign rsp_chan.cells_first  = s2_first_ff;
   assign rsp_chan.cells_second = s2_second_ff;

   // The frame position never leaves the block.
   a_frame_range: assert property (@(posedge clock) disable iff (reset)
      frame_ff <= LAST_FRAME)
      else $error("frame position beyond the block length");

   // The frame advances only after a right subframe has been taken.
   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(frame_ff) |-> $past(req_accept && right_ff))
      else $error("frame position moved without a right subframe");

   // The channel toggles on every accepted item and holds otherwise.
   a_channel_toggle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (right_ff != $past(right_ff)))
      else $error("channel did not alternate");

   // A result is never dropped: a stalled result keeps the output valid.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> s1_valid_ff && s2_valid_ff)
      else $error("pipeline lost an item under stall");

endmodule

@@ tb/tb_spdif_subframe_encoder_top.sv @@
// ----------------------------------------------------------------------------
// S/PDIF subframe encoder testbench
// Drives PCM samples through the valid/ready input channel under every depth,
// rate and mode setting, predicts each biphase-mark subframe in step with the
// block and compares both cell words of every result as it leaves.
// ----------------------------------------------------------------------------
module tb_spdif_subframe_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned IDLE_PERCENT  = 36;
   localparam int unsigned PHASE_ITEMS   = 150;
   localparam int unsigned SETTLE_CYCLES = 6;
   // Register index with no register behind it.
   localparam logic [1:0]  REG_UNUSED    = 2'd3;
   // Depth code with no width of its own, and the rate codes beyond the table.
   localparam logic [1:0]  DEPTH_SPARE       = 2'd3;
   localparam logic [2:0]  RATE_SEL_NONE     = 3'd4;
   localparam logic [2:0]  RATE_SEL_SPARE_LO = 3'd5;
   localparam logic [2:0]  RATE_SEL_SPARE_MD = 3'd6;
   localparam logic [2:0]  RATE_SEL_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [31:0] cells_first;
      logic [31:0] cells_second;
   } subframe_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [sse_pkg::ADDR_W-1:0]  csr_paddr;
   logic [sse_pkg::DATA_W-1:0]  csr_pwdata;
   logic [sse_pkg::DATA_W-1:0]  csr_prdata;
   logic                        csr_pready;

   sse_req_if req_if ();
   sse_rsp_if rsp_if ();

   spdif_subframe_encoder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state: our own copy of the registers and counters.
   logic [1:0]    depth_mirror;
   logic [2:0]    rate_mirror;
   logic          compressed_mirror;
   logic [7:0]    frame_count;
   logic          on_right;

   subframe_type  pending_subframes[$];
   int unsigned   error_count;
   int unsigned   cycle_count;
   logic          no_idle;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_spdif_subframe_encoder_top: errors");
         $finish;
      end
   end

   // The receiving side stalls at random unless a burst is running.
   always @(negedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %08h, expected %08h (cycle %0d)",
               field, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      subframe_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_subframes.size() == 0) begin
            report_mismatch("unexpected subframe", rsp_if.cells_first, 32'd0);
         end else begin
            want = pending_subframes.pop_front();
            if (rsp_if.cells_first !== want.cells_first)
               report_mismatch("cells_first", rsp_if.cells_first, want.cells_first);
            if (rsp_if.cells_second !== want.cells_second)
               report_mismatch("cells_second", rsp_if.cells_second, want.cells_second);
         end
      end
   end

   // Eight slot bits become sixteen cells, the even cell of each pair set.
   function automatic logic [15:0] biphase_cells(input logic [7:0] bits);
      logic [15:0] r;
      for (int i = 0; i < 8; i++) begin
         r[2*i]     = 1'b1;
         r[2*i + 1] = bits[i];
      end
      return r;
   endfunction

   function automatic logic status_bit_for(input logic [7:0] frame);
      logic [7:0] byte_val;
      byte_val = '0;
      if (frame[7:3] == sse_pkg::CS_IDX_BYTE0) begin
         byte_val = compressed_mirror ? sse_pkg::CS_BYTE0_NONPCM : sse_pkg::CS_BYTE0_PCM;
      end else if (frame[7:3] == sse_pkg::CS_IDX_RATE) begin
         case (rate_mirror)
            sse_pkg::RATE_SEL_44K1: byte_val = sse_pkg::RATE_CODE_44K1;
            sse_pkg::RATE_SEL_48K:  byte_val = sse_pkg::RATE_CODE_48K;
            sse_pkg::RATE_SEL_88K2: byte_val = sse_pkg::RATE_CODE_88K2;
            sse_pkg::RATE_SEL_96K:  byte_val = sse_pkg::RATE_CODE_96K;
            default:                byte_val = sse_pkg::RATE_CODE_NONE;
         endcase
      end else if (frame[7:3] == sse_pkg::CS_IDX_DEPTH) begin
         byte_val = (depth_mirror == sse_pkg::DEPTH_16) ? sse_pkg::CS_BYTE4_16BIT
                                                        : sse_pkg::CS_BYTE4_24BIT;
      end
      return byte_val[frame[2:0]];
   endfunction

   // Works out the subframe for one accepted item and advances the counters.
   task automatic predict_subframe(input logic [31:0] smp, input logic absent);
      logic [31:0]  aligned;
      logic [31:0]  slots;
      logic [7:0]   preamble;
      logic [15:0]  top_nibble;
      subframe_type sf;
      aligned = absent ? 32'd0 : smp;
      if (frame_count >= sse_pkg::BLOCK_FRAMES) frame_count = '0;
      if (depth_mirror == sse_pkg::DEPTH_16)      aligned = aligned << 8;
      else if (depth_mirror == sse_pkg::DEPTH_32) aligned = aligned >> 8;
      slots = {1'b0, status_bit_for(frame_count), 1'b0, compressed_mirror,
               aligned[23:0], 4'b0000};
      slots[31] = ^slots[30:0];
      if (on_right)               preamble = sse_pkg::PRE_Y;
      else if (frame_count != '0) preamble = sse_pkg::PRE_X;
      else                        preamble = sse_pkg::PRE_Z;
      top_nibble = biphase_cells({4'b0000, slots[15:12]});
      sf.cells_first  = {top_nibble[7:0], biphase_cells(slots[11:4]), preamble};
      sf.cells_second = {biphase_cells(slots[31:24]), biphase_cells(slots[23:16])};
      pending_subframes.push_back(sf);
      if (on_right) begin
         on_right = 1'b0;
         frame_count = (frame_count + 8'd1 >= sse_pkg::BLOCK_FRAMES) ? 8'd0
                                                                     : frame_count + 8'd1;
      end else begin
         on_right = 1'b1;
      end
   endtask

   task automatic send_sample(input logic [31:0] smp, input logic absent);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid         <= 1'b0;
         req_if.sample        <= $urandom;
         req_if.sample_absent <= $urandom_range(1);
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.sample        <= smp;
      req_if.sample_absent <= absent;
      do @(posedge clock); while (!req_if.ready);
      predict_subframe(smp, absent);
   endtask

   // Stops the input and waits until the block has nothing left in flight.
   task automatic drain_block;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_subframes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         sse_pkg::REG_DEPTH:      depth_mirror      = value[1:0];
         sse_pkg::REG_RATE:       rate_mirror       = value[2:0];
         sse_pkg::REG_COMPRESSED: compressed_mirror = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [1:0] depth, input logic [2:0] rate,
                                 input logic compressed);
      write_register(sse_pkg::REG_DEPTH, {30'd0, depth});
      write_register(sse_pkg::REG_RATE, {29'd0, rate});
      write_register(sse_pkg::REG_COMPRESSED, {31'd0, compressed});
   endtask

   function automatic logic [31:0] random_sample(input logic [1:0] depth);
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(3) == 0) return r;
      case (depth)
         sse_pkg::DEPTH_16: return {{16{r[15]}}, r[15:0]};
         sse_pkg::DEPTH_32: return r;
         default:           return {{8{r[23]}}, r[23:0]};
      endcase
   endfunction

   task automatic test_reset_defaults;
      send_sample(32'h007f_ffff, 1'b0);
      send_sample(32'hff80_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hffff_ffff, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7fff_ffff, 1'b0);
      drain_block();
   endtask

   task automatic test_depth_and_mode_extremes;
      // Only the low bits of each register count; the rest are dropped.
      write_register(sse_pkg::REG_DEPTH, 32'hffff_fffc);
      send_sample(32'h0000_7fff, 1'b0);
      send_sample(32'hffff_8000, 1'b0);
      send_sample(32'hffff_ffff, 1'b0);
      drain_block();
      apply_settings(sse_pkg::DEPTH_32, sse_pkg::RATE_SEL_96K, 1'b1);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_00ff, 1'b0);
      send_sample(32'h1234_5678, 1'b1);
      drain_block();
      // The unused depth code behaves as 24 bits, unused rate codes as none.
      apply_settings(DEPTH_SPARE, RATE_SEL_SPARE_HI, 1'b0);
      write_register(REG_UNUSED, 32'hffff_ffff);
      send_sample(32'h00ff_ffff, 1'b0);
      send_sample(32'h0080_0000, 1'b0);
      send_sample(32'h5555_5555, 1'b0);
      drain_block();
      apply_settings(sse_pkg::DEPTH_16, RATE_SEL_SPARE_LO, 1'b1);
      send_sample(32'haaaa_aaaa, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h0000_0000, 1'b1);
      drain_block();
   endtask

   task automatic run_random_phase(input logic [1:0] depth, input logic [2:0] rate,
                                   input logic compressed, input logic burst);
      apply_settings(depth, rate, compressed);
      no_idle = burst;
      for (int n = 0; n < PHASE_ITEMS; n++)
         send_sample(random_sample(depth), $urandom_range(9) == 0);
      drain_block();
      no_idle = 1'b0;
   endtask

   task automatic test_random_settings;
      run_random_phase(sse_pkg::DEPTH_16, sse_pkg::RATE_SEL_44K1, 1'b0, 1'b0);
      run_random_phase(sse_pkg::DEPTH_32, RATE_SEL_NONE, 1'b1, 1'b0);
      run_random_phase(sse_pkg::DEPTH_24, sse_pkg::RATE_SEL_96K, 1'b0, 1'b1);
      run_random_phase(DEPTH_SPARE, RATE_SEL_SPARE_HI, 1'b1, 1'b0);
      run_random_phase(sse_pkg::DEPTH_16, sse_pkg::RATE_SEL_88K2, 1'b1, 1'b0);
      run_random_phase(sse_pkg::DEPTH_32, RATE_SEL_SPARE_MD, 1'b0, 1'b0);
      run_random_phase(sse_pkg::DEPTH_24, sse_pkg::RATE_SEL_48K, 1'b0, 1'b0);
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      no_idle              = 1'b0;
      error_count          = 0;
      cycle_count          = 0;
      req_if.valid         = 1'b0;
      req_if.sample        = '0;
      req_if.sample_absent = 1'b0;
      rsp_if.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      depth_mirror         = sse_pkg::DEPTH_24;
      rate_mirror          = sse_pkg::RATE_SEL_48K;
      compressed_mirror    = 1'b0;
      frame_count          = '0;
      on_right             = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_depth_and_mode_extremes();
      test_random_settings();

      if (error_count == 0) begin
         $display("tb_spdif_subframe_encoder_top: clean");
      end else begin
         $display("tb_spdif_subframe_encoder_top: errors");
      end
      $finish;
   end

endmodule

@@ spdif_subframe_encoder_top.f @@
rtl/core/sse_pkg.sv
rtl/core/sse_channels.sv
rtl/core/sse_csr.sv
rtl/core/spdif_subframe_encoder_top.sv
tb/tb_spdif_subframe_encoder_top.sv
